// File: hdl/aenc_pkg.sv
`timescale 1ns / 1ps
// shared item types and fixed constants of the arithmetic encoder
package aenc_pkg;

    localparam int CFG_W       = 15;
    localparam int MAX_RESULTS = 36;
    localparam int RES_IDX_W   = 6;

    typedef struct packed {
        logic [13:0] cum_low;
        logic [14:0] cum_high;
        logic        is_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       overflow;
    } t_out_item;

endpackage

// File: hdl/arithmetic_encoder_16bit_unit.sv
`timescale 1ns / 1ps
// top level of the static-model arithmetic encoder with follow bits and byte packing
//
//  channel | signals                          | direction | carries
//  --------+----------------------------------+-----------+------------------------------
//  input   | i_in_valid, o_in_stall, i_in     | in        | symbol counts or end marker
//  output  | o_out_valid, i_out_stall, o_out  | out       | packed byte, last, overflow
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_data | in    | total_count
//
// one item at a time: the serial multiply/divide unit scales the high and then
// the low bound, then the interval is renormalized with its follow bits, and
// then the bytes are delivered
// bytes of an item are buffered and sent once the item is done, so that the
// overflow flag and the last marker are final on every byte
// synchronous active-low reset; o_in_stall is high whenever an item is in work
module arithmetic_encoder_16bit_unit #(
    parameter int RANGE_BITS  = 16,
    parameter int FOLLOW_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  aenc_pkg::t_in_item             i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output aenc_pkg::t_out_item            o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [aenc_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int RB       = RANGE_BITS;
    localparam int FB       = FOLLOW_BITS;
    localparam int ITER_MAX = 2 * RB + 2;
    localparam int IW       = $clog2(ITER_MAX + 1);
    localparam int NW       = aenc_pkg::RES_IDX_W;
    localparam logic [RB-1:0] QTR     = RB'(1) << (RB - 2);
    localparam logic [RB-2:0] QTR_T   = (RB-1)'(1) << (RB - 2);
    localparam logic [FB-1:0] FOLLOW_MAX = {FB{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_HI,
        S_LO,
        S_RENORM,
        S_FOLLOW,
        S_ENDBIT,
        S_CLOSE,
        S_READ,
        S_SHOW
    } t_state;

    t_state                 r_state;
    t_state                 r_ret;
    logic [aenc_pkg::CFG_W-1:0] r_total;
    logic [RB-2:0]          r_tot;
    logic [14:0]            r_ch;
    logic [14:0]            r_cl;
    logic                   r_end;
    logic [RB-1:0]          r_low;
    logic [RB-1:0]          r_high;
    logic [RB:0]            r_qh;
    logic [FB-1:0]          r_follow;
    logic                   r_fbit;
    logic [3:0]             r_bfree;
    logic [7:0]             r_partial;
    logic                   r_ovf;
    logic [IW-1:0]          r_iter;
    logic                   r_start;
    logic [NW-1:0]          r_wcnt;
    logic [NW-1:0]          r_rd;
    logic [7:0]             r_rdata;
    logic                   r_ovalid;
    logic [7:0]             r_mem [aenc_pkg::MAX_RESULTS];

    // scaling unit hookup
    logic                   sc_done;
    logic [RB:0]            sc_q;
    logic [RB:0]            diff;

    assign diff = {1'b0, r_high} - {1'b0, r_low} + 1'b1;

    aenc_scale #(.RB(RB)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_c     ((r_state == S_LO) ? r_cl : r_ch),
        .i_d     (diff),
        .i_t     (r_tot),
        .o_done  (sc_done),
        .o_q     (sc_q)
    );

    // input acceptance and clamping of counts
    logic                   in_acc;
    logic [RB-1:0]          total_ext;
    logic [RB-2:0]          tot_cl;
    logic [RB-2:0]          ch_ext;
    logic [RB-2:0]          ch_sat;
    logic [RB-2:0]          cl_ext;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign total_ext = RB'(r_total);
    assign tot_cl    = (total_ext < RB'(2)) ? (RB-1)'(2) :
                       ((total_ext > QTR) ? QTR_T : total_ext[RB-2:0]);
    assign ch_ext    = (RB-1)'(i_in.cum_high);
    assign cl_ext    = (RB-1)'(i_in.cum_low);

    always_comb begin
        ch_sat = (ch_ext > tot_cl) ? tot_cl : ch_ext;
        if (ch_sat == '0) ch_sat = (RB-1)'(1);
    end

    // renormalization decode, one shift per cycle, paused while follow bits are sent
    logic                   rn_zero;
    logic                   rn_one;
    logic                   rn_mid;
    logic                   rn_stop;
    logic [RB-1:0]          rn_low;
    logic [RB-1:0]          rn_high;

    assign rn_zero = !r_high[RB-1];
    assign rn_one  = !rn_zero && r_low[RB-1];
    assign rn_mid  = !rn_zero && !rn_one && r_low[RB-2] && !r_high[RB-2];
    assign rn_stop = (r_iter == IW'(ITER_MAX)) || !(rn_zero || rn_one || rn_mid);

    always_comb begin
        rn_low  = rn_mid ? (r_low - QTR) : r_low;
        rn_high = rn_mid ? (r_high - QTR) : r_high;
    end

    // bit packer: at most one bit per cycle
    logic                   pb_en;
    logic                   pb_bit;
    logic [7:0]             pb_byte;
    logic                   wr_en;
    logic [7:0]             wr_data;
    logic [7:0]             closing;
    logic                   end_bit;

    assign end_bit = (r_low >= QTR);

    always_comb begin
        pb_en  = 1'b0;
        pb_bit = 1'b0;
        case (r_state)
            S_RENORM: begin
                pb_en  = !rn_stop && (rn_zero || rn_one);
                pb_bit = rn_one;
            end
            S_FOLLOW: begin
                pb_en  = 1'b1;
                pb_bit = r_fbit;
            end
            S_ENDBIT: begin
                pb_en  = 1'b1;
                pb_bit = end_bit;
            end
            default: begin
                pb_en  = 1'b0;
                pb_bit = 1'b0;
            end
        endcase
    end

    assign pb_byte = {pb_bit, r_partial[7:1]};
    assign closing = (r_bfree >= 4'd8) ? 8'd0 : (r_partial >> r_bfree);
    assign wr_en   = (pb_en && (r_bfree <= 4'd1)) || (r_state == S_CLOSE);
    assign wr_data = (r_state == S_CLOSE) ? closing : pb_byte;

    // result buffer, held until the item is done
    always_ff @(posedge i_clk) begin
        if (wr_en && (r_wcnt < NW'(aenc_pkg::MAX_RESULTS))) begin
            r_mem[r_wcnt] <= wr_data;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_mem[r_rd];
        end
    end

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= aenc_pkg::CFG_W'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_total <= i_cfg_data;
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_RENORM;
            r_low     <= '0;
            r_high    <= '1;
            r_follow  <= '0;
            r_bfree   <= 4'd8;
            r_partial <= '0;
            r_ovf     <= 1'b0;
            r_iter    <= '0;
            r_start   <= 1'b0;
            r_wcnt    <= '0;
            r_rd      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_tot   <= tot_cl;
                        r_end   <= i_in.is_end;
                        // end marker encodes the interval [0,1)
                        if (i_in.is_end) begin
                            r_ch <= 15'd1;
                            r_cl <= 15'd0;
                        end else begin
                            r_ch <= ch_sat[14:0];
                            r_cl <= (cl_ext >= ch_sat) ? (ch_sat[14:0] - 15'd1)
                                                       : cl_ext[14:0];
                        end
                        r_start <= 1'b1;
                        r_state <= S_HI;
                    end
                end
                S_HI: begin
                    if (sc_done) begin
                        r_qh    <= sc_q;
                        r_start <= 1'b1;
                        r_state <= S_LO;
                    end
                end
                S_LO: begin
                    if (sc_done) begin
                        r_high  <= RB'({1'b0, r_low} + r_qh - 1'b1);
                        r_low   <= RB'({1'b0, r_low} + sc_q);
                        r_iter  <= '0;
                        r_state <= S_RENORM;
                    end
                end
                S_RENORM: begin
                    if (rn_stop) begin
                        if (r_end) begin
                            r_state <= S_ENDBIT;
                        end else if (r_wcnt == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end else begin
                        r_low  <= {rn_low[RB-2:0], 1'b0};
                        r_high <= {rn_high[RB-2:0], 1'b1};
                        r_iter <= r_iter + 1'b1;
                        if (rn_mid) begin
                            if (r_follow == FOLLOW_MAX) r_ovf <= 1'b1;
                            else r_follow <= r_follow + 1'b1;
                        end else begin
                            r_fbit <= rn_zero;
                            r_ret  <= S_RENORM;
                            if (r_follow != '0) r_state <= S_FOLLOW;
                        end
                    end
                end
                S_FOLLOW: begin
                    r_follow <= r_follow - 1'b1;
                    if (r_follow == FB'(1)) r_state <= r_ret;
                end
                S_ENDBIT: begin
                    // one more follow; the disambiguating bit is packed here, then the follows
                    if (r_follow == FOLLOW_MAX) r_ovf <= 1'b1;
                    else r_follow <= r_follow + 1'b1;
                    r_fbit  <= !end_bit;
                    r_ret   <= S_CLOSE;
                    r_state <= S_FOLLOW;
                end
                S_CLOSE: begin
                    r_low   <= '0;
                    r_high  <= '1;
                    r_follow <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_SHOW;
                end
                S_SHOW: begin
                    if (!i_out_stall) begin
                        r_ovalid <= 1'b0;
                        if (r_rd == r_wcnt - 1'b1) begin
                            r_rd    <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_rd    <= r_rd + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // packer update and buffer fill count
            if (pb_en) begin
                r_partial <= pb_byte;
                r_bfree   <= (r_bfree > 4'd1) ? (r_bfree - 4'd1) : 4'd8;
            end
            if (r_state == S_CLOSE) begin
                r_partial <= '0;
                r_bfree   <= 4'd8;
            end
            if (wr_en && (r_wcnt < NW'(aenc_pkg::MAX_RESULTS))) begin
                r_wcnt <= r_wcnt + 1'b1;
            end
            if ((r_state == S_SHOW) && !i_out_stall && (r_rd == r_wcnt - 1'b1)) begin
                r_wcnt <= '0;
            end
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_ovalid;
    assign o_out.out_byte    = r_rdata;
    assign o_out.last        = (r_rd == r_wcnt - 1'b1);
    assign o_out.overflow    = r_ovf;

endmodule

// File: hdl/aenc_scale.sv
`timescale 1ns / 1ps
// bit-serial unit computing floor(c * d / t): shift-add multiply, then restoring divide
module aenc_scale #(
    parameter int RB = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [14:0]   i_c,
    input  logic [RB:0]   i_d,
    input  logic [RB-2:0] i_t,
    output logic          o_done,
    output logic [RB:0]   o_q
);

    localparam int PW  = RB + 16;
    localparam int CW  = $clog2(PW + 1);

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV
    } t_sc_state;

    t_sc_state       r_state;
    logic [CW-1:0]   r_cnt;
    logic [RB:0]     r_d;
    logic [14:0]     r_c;
    logic [RB-2:0]   r_t;
    logic [PW-1:0]   r_acc;
    logic [RB-2:0]   r_rem;
    logic [RB:0]     r_q;
    logic            r_done;

    logic [RB-2:0]   rem_sh;
    logic            q_bit;

    assign rem_sh = {r_rem[RB-3:0], r_acc[PW-1]};
    assign q_bit  = (rem_sh >= r_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                SC_IDLE: begin
                    if (i_start) begin
                        r_c     <= i_c;
                        r_d     <= i_d;
                        r_t     <= i_t;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= SC_MUL;
                    end
                end
                SC_MUL: begin
                    // msb-first shift-add over the bits of d
                    r_acc <= {r_acc[PW-2:0], 1'b0}
                             + (r_d[RB] ? {{(PW-15){1'b0}}, r_c} : {PW{1'b0}});
                    r_d   <= {r_d[RB-1:0], 1'b0};
                    if (r_cnt == CW'(RB)) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_state <= SC_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                SC_DIV: begin
                    r_rem <= q_bit ? (rem_sh - r_t) : rem_sh;
                    r_q   <= {r_q[RB-1:0], q_bit};
                    r_acc <= {r_acc[PW-2:0], 1'b0};
                    if (r_cnt == CW'(PW - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= SC_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= SC_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the arithmetic encoder with byte packing and follow bits
module testbench;

    localparam int RNG_BITS  = 16;
    localparam int FOL_BITS  = 8;
    localparam logic [31:0] RNG_TOP  = 32'h0000_FFFF;
    localparam logic [31:0] RNG_HALF = 32'h0000_8000;
    localparam logic [31:0] RNG_QTR  = 32'h0000_4000;
    localparam int FOL_MAX   = (1 << FOL_BITS) - 1;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    aenc_pkg::t_in_item i_in;
    logic o_out_valid;
    logic i_out_stall;
    aenc_pkg::t_out_item o_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [aenc_pkg::CFG_W-1:0] i_cfg_data;

    arithmetic_encoder_16bit_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // encoder state mirror
    logic [31:0] enc_low;
    logic [31:0] enc_high;
    int          enc_follows;
    int          enc_free;
    logic [7:0]  enc_partial;
    logic        enc_ovf;
    logic [14:0] enc_total;

    aenc_pkg::t_out_item expected_bytes[$];
    logic [7:0]  item_bytes[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // bit packing, first bit ends up in bit 0
    task automatic pack_bit(input logic b);
        enc_partial = {b, enc_partial[7:1]};
        if (enc_free > 1) begin
            enc_free--;
        end else begin
            if (item_bytes.size() < aenc_pkg::MAX_RESULTS) item_bytes = {item_bytes, enc_partial};
            enc_free = 8;
        end
    endtask

    task automatic pack_with_follows(input logic b);
        pack_bit(b);
        while (enc_follows > 0) begin
            pack_bit(~b);
            enc_follows--;
        end
    endtask

    task automatic count_follow();
        if (enc_follows >= FOL_MAX) begin
            enc_follows = FOL_MAX;
            enc_ovf = 1'b1;
        end else begin
            enc_follows++;
        end
    endtask

    task automatic narrow_interval(input logic [31:0] cl, input logic [31:0] ch,
                                   input logic [31:0] tot);
        logic [31:0] span;
        logic [31:0] base;
        span = enc_high - enc_low + 1;
        base = enc_low;
        enc_high = base + (ch * span) / tot - 1;
        enc_low = base + (cl * span) / tot;
        for (int k = 0; k < 2 * RNG_BITS + 2; k++) begin
            if (enc_high < RNG_HALF) begin
                pack_with_follows(1'b0);
            end else if (enc_low >= RNG_HALF) begin
                pack_with_follows(1'b1);
                enc_low -= RNG_HALF;
                enc_high -= RNG_HALF;
            end else if (enc_low >= RNG_QTR && enc_high < 3 * RNG_QTR) begin
                count_follow();
                enc_low -= RNG_QTR;
                enc_high -= RNG_QTR;
            end else begin
                break;
            end
            enc_low = (enc_low << 1) & RNG_TOP;
            enc_high = ((enc_high << 1) | 1) & RNG_TOP;
        end
    endtask

    task automatic clear_coder();
        enc_low = 0;
        enc_high = RNG_TOP;
        enc_follows = 0;
        enc_free = 8;
        enc_partial = 8'h00;
    endtask

    // predicts the bytes of one accepted item
    task automatic encode_item(input aenc_pkg::t_in_item it);
        logic [31:0] tot, cl, ch;
        logic [7:0] close_byte;
        aenc_pkg::t_out_item r;
        tot = enc_total;
        cl = it.cum_low;
        ch = it.cum_high;
        item_bytes.delete();
        if (tot < 2) tot = 2;
        if (tot > RNG_QTR) tot = RNG_QTR;
        if (!it.is_end) begin
            if (ch > tot) ch = tot;
            if (ch < 1) ch = 1;
            if (cl >= ch) cl = ch - 1;
            narrow_interval(cl, ch, tot);
        end else begin
            narrow_interval(0, 1, tot);
            count_follow();
            pack_with_follows(enc_low < RNG_QTR ? 1'b0 : 1'b1);
            close_byte = (enc_free >= 8) ? 8'h00 : (enc_partial >> enc_free);
            if (item_bytes.size() < aenc_pkg::MAX_RESULTS)
                item_bytes = {item_bytes, close_byte};
            clear_coder();
        end
        foreach (item_bytes[k]) begin
            r.out_byte = item_bytes[k];
            r.last = (k == item_bytes.size() - 1);
            r.overflow = enc_ovf;
            expected_bytes = {expected_bytes, r};
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", o_out.out_byte));
            end else begin
                aenc_pkg::t_out_item e;
                e = expected_bytes.pop_front();
                if (o_out.out_byte !== e.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              o_out.out_byte, e.out_byte));
                if (o_out.last !== e.last)
                    report_mismatch($sformatf("last %b, want %b", o_out.last, e.last));
                if (o_out.overflow !== e.overflow)
                    report_mismatch($sformatf("overflow %b, want %b",
                                              o_out.overflow, e.overflow));
            end
        end
    end

    // receiver stall, random or held for a counted stretch
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // sends one item, with random idle after it
    task automatic send_item(input aenc_pkg::t_in_item it);
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        encode_item(it);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
    endtask

    task automatic send_symbol(input int cl, input int ch);
        aenc_pkg::t_in_item it;
        it.cum_low = cl[13:0];
        it.cum_high = ch[14:0];
        it.is_end = 1'b0;
        send_item(it);
    endtask

    task automatic send_end(input logic [28:0] junk);
        aenc_pkg::t_in_item it;
        it = {junk, 1'b1};
        send_item(it);
    endtask

    task automatic drain_results();
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [aenc_pkg::CFG_W-1:0] val);
        drain_results();
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        enc_total = val;
    endtask

    // random well-formed symbol under the current total
    task automatic send_random_symbol();
        int tot, cl, ch;
        tot = (enc_total < 2) ? 2 : (enc_total > 16384 ? 16384 : enc_total);
        cl = $urandom_range(tot - 1);
        ch = $urandom_range(tot, cl + 1);
        send_symbol(cl, ch);
    endtask

    task automatic test_directed();
        write_total(15'd2);
        send_symbol(0, 1);
        send_symbol(1, 2);
        send_end('0);
        write_total(15'd16384);
        send_symbol(0, 16384);
        send_symbol(16383, 16384);
        send_symbol(0, 1);
        send_symbol(8000, 8400);
        send_end('1);
        // out-of-range counts get clipped
        send_symbol(16383, 0);
        send_symbol(100, 20000);
        send_symbol(5, 5);
        send_end('0);
        // an end right after another leaves no pending bits
        send_end('0);
        write_total(15'd0);
        send_symbol(0, 1);
        send_end('0);
        write_total(15'h7FFF);
        send_symbol(3, 10);
        send_symbol(16383, 32767);
        send_end('0);
    endtask

    // centered narrow symbols pile up follow bits until the counter saturates
    task automatic test_follow_saturation();
        write_total(15'd16384);
        for (int k = 0; k < 40; k++) send_symbol(8100, 8284);
        send_end('0);
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) == 0) send_end(29'($urandom));
            else if ($urandom_range(19) == 0) begin
                aenc_pkg::t_in_item it;
                it = 30'($urandom);
                it.is_end = 1'b0;
                send_item(it);
            end else send_random_symbol();
        end
        send_end('0);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 2000;
        for (int k = 0; k < 20; k++) send_random_symbol();
        send_end('0);
        drain_results();
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        enc_ovf = 1'b0;
        enc_total = 15'd2;
        clear_coder();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_follow_saturation();
        write_total(15'd300);
        test_random(80);
        send_idle_pct = 56;
        write_total(15'd16384);
        test_random(80);
        send_idle_pct = 0;
        recv_stall_pct = 56;
        write_total(15'd3);
        test_random(60);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        write_total(15'($urandom_range(16384, 2)));
        test_random(80);
        test_backpressure();

        drain_results();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
